>>> design/clq_pkg.sv
// ----------------------------------------------------------------------------
// Command link queue package
// Shared types, codes and reset values of the command link transaction queue.
// ----------------------------------------------------------------------------
package clq_pkg;

  localparam int unsigned DEPTH_DEF = 8;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REPLY  = 2'd2;

  localparam logic [1:0] CLS_EMPTY  = 2'd0;
  localparam logic [1:0] CLS_MOTION = 2'd2;
  localparam logic [1:0] CLS_URGENT = 2'd3;

  localparam logic [1:0] RK_NONE = 2'd0;
  localparam logic [1:0] RK_IMM  = 2'd1;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_SEND  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_UNSOL = 2'd3;

  localparam logic [1:0] OC_REPLY    = 2'd0;
  localparam logic [1:0] OC_REJECTED = 2'd1;
  localparam logic [1:0] OC_TIMEOUT  = 2'd2;
  localparam logic [1:0] OC_NOREPLY  = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_AWAIT = 2'd1;
  localparam logic [1:0] PH_GRACE = 2'd2;

  localparam logic [1:0] CFG_REPLY_TO = 2'd0;
  localparam logic [1:0] CFG_GRACE    = 2'd1;
  localparam logic [1:0] CFG_LOCKOUT  = 2'd2;
  localparam logic [1:0] CFG_TO_LIMIT = 2'd3;

  localparam logic [15:0] RST_REPLY_TO = 16'd300;
  localparam logic [15:0] RST_GRACE    = 16'd80;
  localparam logic [15:0] RST_LOCKOUT  = 16'd5500;
  localparam logic [3:0]  RST_TO_LIMIT = 4'd5;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] tag;
    logic [1:0]  cls;
    logic [1:0]  kind;
    logic [1:0]  src;
  } entry_t;

endpackage

>>> design/command_link_transaction_queue.sv
// ----------------------------------------------------------------------------
// Command link transaction queue
// Queues tagged commands in a ring memory and runs one transaction at a time.
// ----------------------------------------------------------------------------
// One input transfer at a time. A submit walks the queue entries for the motion
// supersede or stop purge search, and each entry walked costs one read of the
// queue memory and one inspect state. Results wait in an output register, and
// processing stalls while that register is full and not taken.
// Reset is synchronous; the queue memory needs no clearing.
module command_link_transaction_queue #(
  parameter int unsigned DEPTH = clq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd_tag, cmd_class, reply_kind, requester, reply_is_error, reply_tag
  input  logic [39:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // txn_id, owner, outcome, sent_tag, answer_tag, link_up
  output logic [71:0] out_tdata,
  // out_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRD   = 3'd1;
  localparam logic [2:0] S_SCHK  = 3'd2;
  localparam logic [2:0] S_SACK  = 3'd3;
  localparam logic [2:0] S_APP   = 3'd4;
  localparam logic [2:0] S_TRD   = 3'd5;
  localparam logic [2:0] S_START = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] b,
                                             input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[IW-1:0];
  endfunction

  logic [15:0] reply_to_r, grace_r, lockout_cfg_r;
  logic [3:0]  to_limit_r;

  logic [2:0]  state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt, hit_r, hit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, scan_i_r, scan_i_nxt, keep_k_r, keep_k_nxt;
  logic [31:0] nid_r, nid_nxt;
  clq_pkg::entry_t act_r, act_nxt, req_r, req_nxt, rd_data_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] elap_r, elap_nxt, lock_r, lock_nxt;
  logic [3:0]  trun_r, trun_nxt;
  logic        healthy_r, healthy_nxt;
  logic [1:0]  fin_oc_r, fin_oc_nxt;
  logic        fin_err_r, fin_err_nxt;
  logic [15:0] fin_ans_r, fin_ans_nxt;

  clq_pkg::entry_t mem [DEPTH];
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  clq_pkg::entry_t mem_wdata;

  logic        emit, emit_ok, e_last, e_link;
  logic [1:0]  e_kind, e_owner, e_oc;
  logic [31:0] e_id, nid_inc;
  logic [15:0] e_sent, e_ans, lim;
  logic [3:0]  trun_up;

  logic        out_valid_r, out_last_r;
  logic [71:0] out_data_r;
  logic [1:0]  out_kind_r;

  assign in_tready  = (state_r == S_IDLE);
  assign emit_ok    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign nid_inc    = (nid_r + 32'd1 == 32'd0) ? 32'd1 : nid_r + 32'd1;
  assign lim        = (phase_r == clq_pkg::PH_AWAIT) ? reply_to_r : grace_r;
  assign trun_up    = (trun_r < 4'd15) ? trun_r + 4'd1 : trun_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    hit_nxt     = hit_r;
    cnt_nxt     = cnt_r;
    scan_i_nxt  = scan_i_r;
    keep_k_nxt  = keep_k_r;
    nid_nxt     = nid_r;
    act_nxt     = act_r;
    req_nxt     = req_r;
    phase_nxt   = phase_r;
    elap_nxt    = elap_r;
    lock_nxt    = lock_r;
    trun_nxt    = trun_r;
    healthy_nxt = healthy_r;
    fin_oc_nxt  = fin_oc_r;
    fin_err_nxt = fin_err_r;
    fin_ans_nxt = fin_ans_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = head_r;
    mem_raddr   = head_r;
    mem_wdata   = req_r;
    emit        = 1'b0;
    e_kind      = clq_pkg::KIND_ACK;
    e_id        = 32'd0;
    e_owner     = req_r.src;
    e_oc        = clq_pkg::OC_REPLY;
    e_sent      = 16'd0;
    e_ans       = 16'd0;
    e_last      = 1'b1;
    e_link      = healthy_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt.id   = 32'd0;
          req_nxt.tag  = in_tdata[15:0];
          req_nxt.cls  = in_tdata[17:16];
          req_nxt.kind = in_tdata[19:18];
          req_nxt.src  = in_tdata[21:20];
          fin_err_nxt  = in_tdata[22];
          fin_ans_nxt  = in_tdata[38:23];
          scan_i_nxt   = '0;
          keep_k_nxt   = '0;
          unique case (in_tuser)
            clq_pkg::OP_SUBMIT: begin
              if ((in_tdata[17:16] == clq_pkg::CLS_MOTION ||
                   in_tdata[17:16] == clq_pkg::CLS_URGENT) && cnt_r != '0) begin
                state_nxt = S_SRD;
              end else begin
                state_nxt = S_APP;
              end
            end
            clq_pkg::OP_TICK: begin
              if (lock_r != 16'd0) lock_nxt = lock_r - 16'd1;
              if (phase_r == clq_pkg::PH_IDLE) begin
                if (cnt_r != '0) state_nxt = S_TRD;
              end else if (elap_r >= lim) begin
                fin_oc_nxt  = (phase_r == clq_pkg::PH_AWAIT) ? clq_pkg::OC_TIMEOUT
                                                              : clq_pkg::OC_NOREPLY;
                fin_ans_nxt = 16'd0;
                state_nxt   = S_FIN;
              end else if (elap_r != 16'hFFFF) begin
                elap_nxt = elap_r + 16'd1;
              end
            end
            clq_pkg::OP_REPLY: begin
              req_nxt.cls = clq_pkg::CLS_EMPTY;
              fin_oc_nxt = in_tdata[22] ? clq_pkg::OC_REJECTED : clq_pkg::OC_REPLY;
              state_nxt  = (phase_r == clq_pkg::PH_IDLE) ? S_SACK : S_FIN;
            end
            default: ;
          endcase
        end
      end
      S_SRD: begin
        mem_re    = 1'b1;
        mem_raddr = wrap_add(head_r, scan_i_r);
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (rd_data_r.cls == clq_pkg::CLS_MOTION) begin
          e_kind  = clq_pkg::KIND_DONE;
          e_id    = rd_data_r.id;
          e_owner = rd_data_r.src;
          e_oc    = clq_pkg::OC_NOREPLY;
          e_last  = 1'b0;
          if (emit_ok) begin
            emit = 1'b1;
            if (req_r.cls == clq_pkg::CLS_MOTION) begin
              hit_nxt   = wrap_add(head_r, scan_i_r);
              phase_nxt = phase_r;
              state_nxt = S_SACK;
            end else begin
              scan_i_nxt = scan_i_r + CW'(1);
              if (scan_i_r + CW'(1) == cnt_r) begin
                cnt_nxt   = keep_k_r;
                state_nxt = S_APP;
              end else begin
                state_nxt = S_SRD;
              end
            end
          end
        end else begin
          scan_i_nxt = scan_i_r + CW'(1);
          if (req_r.cls == clq_pkg::CLS_URGENT) begin
            mem_we     = 1'b1;
            mem_waddr  = wrap_add(head_r, keep_k_r);
            mem_wdata  = rd_data_r;
            keep_k_nxt = keep_k_r + CW'(1);
          end
          if (scan_i_r + CW'(1) == cnt_r) begin
            if (req_r.cls == clq_pkg::CLS_URGENT) cnt_nxt = keep_k_r + CW'(1);
            state_nxt = S_APP;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SACK: begin
        // Supersede acknowledge, or an unsolicited line when a reply came while idle.
        if (req_r.cls == clq_pkg::CLS_MOTION) begin
          e_kind = clq_pkg::KIND_ACK;
          e_id   = nid_r;
        end else begin
          e_kind  = clq_pkg::KIND_UNSOL;
          e_owner = 2'd0;
          e_ans   = fin_ans_r;
        end
        if (emit_ok) begin
          emit = 1'b1;
          if (e_kind == clq_pkg::KIND_ACK) begin
            mem_we       = 1'b1;
            mem_waddr    = hit_r;
            mem_wdata    = req_r;
            mem_wdata.id = nid_r;
            nid_nxt      = nid_inc;
          end
          state_nxt = S_IDLE;
        end
      end
      S_APP: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (req_r.cls != clq_pkg::CLS_EMPTY && cnt_r < CW'(DEPTH)) begin
            e_id         = nid_r;
            nid_nxt      = nid_inc;
            mem_we       = 1'b1;
            mem_wdata.id = nid_r;
            cnt_nxt      = cnt_r + CW'(1);
            if (req_r.cls == clq_pkg::CLS_URGENT) begin
              head_nxt  = (head_r == '0) ? IW'(DEPTH - 1) : head_r - IW'(1);
              mem_waddr = head_nxt;
            end else begin
              mem_waddr = wrap_add(head_r, cnt_r);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      S_TRD: begin
        mem_re    = 1'b1;
        mem_raddr = head_r;
        state_nxt = S_START;
      end
      S_START: begin
        e_kind  = clq_pkg::KIND_SEND;
        e_id    = rd_data_r.id;
        e_owner = rd_data_r.src;
        e_sent  = rd_data_r.tag;
        e_last  = (rd_data_r.kind != clq_pkg::RK_NONE);
        if (lock_r != 16'd0 && rd_data_r.cls == clq_pkg::CLS_MOTION) begin
          act_nxt     = rd_data_r;
          head_nxt    = wrap_add(head_r, CW'(1));
          cnt_nxt     = cnt_r - CW'(1);
          fin_oc_nxt  = clq_pkg::OC_REJECTED;
          fin_ans_nxt = 16'd0;
          state_nxt   = S_FIN;
        end else if (emit_ok) begin
          emit        = 1'b1;
          act_nxt     = rd_data_r;
          head_nxt    = wrap_add(head_r, CW'(1));
          cnt_nxt     = cnt_r - CW'(1);
          elap_nxt    = 16'd0;
          phase_nxt   = (rd_data_r.kind == clq_pkg::RK_IMM) ? clq_pkg::PH_AWAIT
                                                             : clq_pkg::PH_GRACE;
          fin_oc_nxt  = clq_pkg::OC_NOREPLY;
          fin_ans_nxt = 16'd0;
          state_nxt   = (rd_data_r.kind == clq_pkg::RK_NONE) ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (fin_oc_r == clq_pkg::OC_TIMEOUT) begin
          trun_nxt = trun_up;
          if (trun_up >= to_limit_r) healthy_nxt = 1'b0;
        end else if (fin_oc_r == clq_pkg::OC_REPLY || fin_oc_r == clq_pkg::OC_REJECTED) begin
          if (!healthy_r) begin
            lock_nxt    = lockout_cfg_r;
            healthy_nxt = 1'b1;
          end
          trun_nxt = 4'd0;
        end
        e_kind  = clq_pkg::KIND_DONE;
        e_id    = act_r.id;
        e_owner = act_r.src;
        e_oc    = fin_oc_r;
        e_ans   = fin_ans_r;
        e_link  = healthy_nxt;
        if (emit_ok) begin
          emit      = 1'b1;
          phase_nxt = clq_pkg::PH_IDLE;
          state_nxt = S_IDLE;
        end else begin
          trun_nxt    = trun_r;
          healthy_nxt = healthy_r;
          lock_nxt    = lock_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_to_r    <= clq_pkg::RST_REPLY_TO;
      grace_r       <= clq_pkg::RST_GRACE;
      lockout_cfg_r <= clq_pkg::RST_LOCKOUT;
      to_limit_r    <= clq_pkg::RST_TO_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        clq_pkg::CFG_REPLY_TO: reply_to_r    <= cfg_wdata;
        clq_pkg::CFG_GRACE:    grace_r       <= cfg_wdata;
        clq_pkg::CFG_LOCKOUT:  lockout_cfg_r <= cfg_wdata;
        clq_pkg::CFG_TO_LIMIT: to_limit_r    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      nid_r       <= 32'd1;
      act_r       <= '0;
      phase_r     <= clq_pkg::PH_IDLE;
      elap_r      <= 16'd0;
      lock_r      <= clq_pkg::RST_LOCKOUT;
      trun_r      <= 4'd0;
      healthy_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      nid_r     <= nid_nxt;
      act_r     <= act_nxt;
      phase_r   <= phase_nxt;
      elap_r    <= elap_nxt;
      lock_r    <= lock_nxt;
      trun_r    <= trun_nxt;
      healthy_r <= healthy_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    scan_i_r  <= scan_i_nxt;
    keep_k_r  <= keep_k_nxt;
    req_r     <= req_nxt;
    fin_oc_r  <= fin_oc_nxt;
    fin_err_r <= fin_err_nxt;
    fin_ans_r <= fin_ans_nxt;
    if (emit) begin
      out_data_r <= {3'd0, e_link, e_ans, e_sent, e_oc, e_owner, e_id};
      out_kind_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count above depth");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("invalid phase code");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCHK |-> (scan_i_r < cnt_r && keep_k_r <= scan_i_r))
    else $error("scan index out of range");

  a_nid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nid_r != 32'd0) else $error("transaction id counter reached zero");

  a_fin_err: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_oc_r == clq_pkg::OC_REJECTED && fin_ans_r != 16'd0)
    |-> fin_err_r) else $error("rejection with answer but no error flag");

endmodule

>>> dv/tb_command_link_transaction_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command link transaction queue testbench
// Drives submits, millisecond ticks, reply lines and the unused op code under
// random idling on both streams, across several register settings, and checks every
// result transfer against a cycle-free model of the queue and its link phases.
// ----------------------------------------------------------------------------
module tb_command_link_transaction_queue;
  import clq_pkg::*;

  localparam int QD = DEPTH_DEF;

  typedef enum logic [1:0] {ST_IN, ST_CFG, ST_DRAIN} stim_what_t;

  typedef struct {
    stim_what_t  what;
    logic [1:0]  op;
    logic [39:0] data;
    logic [1:0]  addr;
    logic [15:0] wdata;
  } stim_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [1:0]  owner;
    logic [1:0]  outcome;
    logic [15:0] sent;
    logic [15:0] answer;
    logic        link;
    logic        last;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  command_link_transaction_queue dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t stim_q[$];
  res_t  result_q[$];
  int    n_fail = 0;
  int    n_sent = 0;
  int    n_checked = 0;

  // Shadow state of the queue and link.
  entry_t      store[QD];
  int          head, cnt, el, lock, trun;
  logic [31:0] nid;
  entry_t      act;
  logic [1:0]  ph;
  bit          hl;
  int          c_rto, c_grace, c_lock, c_lim;

  task automatic put(logic [1:0] k, logic [31:0] id, logic [1:0] own, logic [1:0] oc,
                     logic [15:0] snt, logic [15:0] ans);
    res_t r;
    r = '{k, id, own, oc, snt, ans, hl, 1'b0};
    result_q.push_back(r);
  endtask

  function automatic logic [31:0] grab_id();
    logic [31:0] id;
    id = nid;
    nid = nid + 1;
    if (nid == 0) nid = 1;
    return id;
  endfunction

  task automatic finish_txn(logic [1:0] oc, logic [15:0] ans);
    ph = PH_IDLE;
    if (oc == OC_TIMEOUT) begin
      if (trun < 15) trun++;
      if (trun >= c_lim) hl = 0;
    end else if (oc == OC_REPLY || oc == OC_REJECTED) begin
      if (!hl) begin
        lock = c_lock;
        hl = 1;
      end
      trun = 0;
    end
    put(KIND_DONE, act.id, act.src, oc, '0, ans);
  endtask

  task automatic purge_motion();
    entry_t kept[QD];
    entry_t e;
    int k;
    k = 0;
    for (int i = 0; i < cnt; i++) begin
      e = store[(head + i) % QD];
      if (e.cls == CLS_MOTION) put(KIND_DONE, e.id, e.src, OC_NOREPLY, '0, '0);
      else begin
        kept[k] = e;
        k++;
      end
    end
    for (int i = 0; i < k; i++) store[i] = kept[i];
    head = 0;
    cnt = k;
  endtask

  task automatic do_submit(logic [39:0] d);
    entry_t req;
    int idx;
    req = '{32'd0, d[15:0], d[17:16], d[19:18], d[21:20]};
    if (req.cls == CLS_EMPTY) begin
      put(KIND_ACK, '0, req.src, OC_REPLY, '0, '0);
      return;
    end
    if (req.cls == CLS_URGENT) purge_motion();
    else if (req.cls == CLS_MOTION) begin
      for (int i = 0; i < cnt; i++) begin
        idx = (head + i) % QD;
        if (store[idx].cls == CLS_MOTION) begin
          put(KIND_DONE, store[idx].id, store[idx].src, OC_NOREPLY, '0, '0);
          req.id = grab_id();
          store[idx] = req;
          put(KIND_ACK, req.id, req.src, OC_REPLY, '0, '0);
          return;
        end
      end
    end
    if (cnt >= QD) begin
      put(KIND_ACK, '0, req.src, OC_REPLY, '0, '0);
      return;
    end
    req.id = grab_id();
    if (req.cls == CLS_URGENT) begin
      head = (head + QD - 1) % QD;
      store[head] = req;
    end else store[(head + cnt) % QD] = req;
    cnt++;
    put(KIND_ACK, req.id, req.src, OC_REPLY, '0, '0);
  endtask

  task automatic do_tick();
    int lim;
    if (lock > 0) lock--;
    if (ph == PH_IDLE) begin
      if (cnt == 0) return;
      act = store[head];
      head = (head + 1) % QD;
      cnt--;
      if (lock > 0 && act.cls == CLS_MOTION) begin
        finish_txn(OC_REJECTED, '0);
        return;
      end
      put(KIND_SEND, act.id, act.src, OC_REPLY, act.tag, '0);
      el = 0;
      ph = (act.kind == RK_IMM) ? PH_AWAIT : PH_GRACE;
      if (act.kind == RK_NONE) finish_txn(OC_NOREPLY, '0);
      return;
    end
    lim = (ph == PH_AWAIT) ? c_rto : c_grace;
    if (el >= lim) finish_txn((ph == PH_AWAIT) ? OC_TIMEOUT : OC_NOREPLY, '0);
    else if (el < 65535) el++;
  endtask

  task automatic predict_transfer(logic [1:0] op, logic [39:0] d);
    int n_prev;
    n_prev = result_q.size();
    case (op)
      OP_SUBMIT: do_submit(d);
      OP_TICK:   do_tick();
      OP_REPLY: begin
        if (ph == PH_IDLE) put(KIND_UNSOL, '0, '0, OC_REPLY, '0, d[38:23]);
        else finish_txn(d[22] ? OC_REJECTED : OC_REPLY, d[38:23]);
      end
      default: ;
    endcase
    if (result_q.size() > n_prev) result_q[$].last = 1'b1;
  endtask

  task automatic set_reg(logic [1:0] a, logic [15:0] v);
    case (a)
      CFG_REPLY_TO: c_rto = v;
      CFG_GRACE:    c_grace = v;
      CFG_LOCKOUT:  c_lock = v;
      default:      c_lim = v[3:0];
    endcase
  endtask

  // Gap lengths: mostly none or short, a few long, with idle-free stretches.
  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 99) < 3) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  int  in_gap = 0;
  int  out_gap = 0;
  int  quiet = 0;
  bit  in_calm = 0;
  bit  out_calm = 0;

  always @(posedge clk) begin
    stim_t s;
    bit hold, nv, we;
    logic [1:0] nop, wa;
    logic [39:0] nd;
    logic [15:0] wd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      hold = 0;
      we = 0;
      nv = 0;
      nop = in_tuser;
      nd = in_tdata;
      wa = cfg_addr;
      wd = cfg_wdata;
      if (in_tvalid && in_tready) begin
        predict_transfer(in_tuser, in_tdata);
        n_sent++;
      end else if (in_tvalid) hold = 1;
      quiet = (result_q.size() == 0 && !in_tvalid && !out_tvalid) ? quiet + 1 : 0;
      if (hold) nv = 1;
      else if (in_gap > 0) in_gap--;
      else if (stim_q.size() > 0) begin
        s = stim_q[0];
        case (s.what)
          ST_DRAIN: if (quiet >= 40) void'(stim_q.pop_front());
          ST_CFG: begin
            void'(stim_q.pop_front());
            we = 1;
            wa = s.addr;
            wd = s.wdata;
            set_reg(s.addr, s.wdata);
          end
          default: begin
            void'(stim_q.pop_front());
            nv = 1;
            nop = s.op;
            nd = s.data;
            in_gap = pick_gap(in_calm);
          end
        endcase
      end
      in_tvalid <= nv;
      in_tuser <= nop;
      in_tdata <= nd;
      cfg_we <= we;
      cfg_addr <= wa;
      cfg_wdata <= wd;
    end
  end

  always @(posedge clk) begin
    res_t got, w;
    bit nr;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[31:0], out_tdata[33:32], out_tdata[35:34],
                out_tdata[51:36], out_tdata[67:52], out_tdata[68], out_tlast};
        n_checked++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, got);
          n_fail++;
        end else begin
          w = result_q.pop_front();
          if (got.kind !== w.kind || got.id !== w.id || got.owner !== w.owner ||
              got.outcome !== w.outcome || got.sent !== w.sent ||
              got.answer !== w.answer || got.link !== w.link || got.last !== w.last) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, w, got);
            n_fail++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        nr = 0;
      end else begin
        nr = 1;
        if (out_tvalid && out_tready) out_gap = pick_gap(out_calm);
      end
      out_tready <= nr;
    end
  end

  task automatic add_in(logic [1:0] op, logic [15:0] tag, logic [1:0] cls, logic [1:0] rk,
                        logic [1:0] req, logic err, logic [15:0] rtag);
    stim_t s;
    s = '{ST_IN, op, {1'b0, rtag, err, req, rk, cls, tag}, 2'd0, 16'd0};
    stim_q.push_back(s);
  endtask

  task automatic add_setting(int rto, int grace, int lk, int lim);
    stim_t s;
    stim_q.push_back('{ST_DRAIN, 2'd0, 40'd0, 2'd0, 16'd0});
    s = '{ST_CFG, 2'd0, 40'd0, CFG_REPLY_TO, 16'(rto)};
    stim_q.push_back(s);
    s.addr = CFG_GRACE;
    s.wdata = 16'(grace);
    stim_q.push_back(s);
    s.addr = CFG_LOCKOUT;
    s.wdata = 16'(lk);
    stim_q.push_back(s);
    s.addr = CFG_TO_LIMIT;
    s.wdata = 16'(lim);
    stim_q.push_back(s);
  endtask

  task automatic add_random(int n);
    int r, k;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) add_in(2'd3, 16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
                        1'($urandom), 16'($urandom));
      else if (r < 9) begin
        for (int i = 0; i < 9; i++)
          add_in(OP_SUBMIT, 16'($urandom), 2'($urandom_range(1, 3)), 2'($urandom),
                 2'($urandom), 1'($urandom), 16'($urandom));
        k += 9;
      end else if (r < 45) begin
        add_in(OP_SUBMIT, 16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
               1'($urandom), 16'($urandom));
        k++;
      end else if (r < 82) begin
        add_in(OP_TICK, 16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
               1'($urandom), 16'($urandom));
        k++;
      end else begin
        add_in(OP_REPLY, 16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
               1'($urandom), 16'($urandom));
        k++;
      end
    end
  endtask

  initial begin
    head = 0;
    cnt = 0;
    nid = 1;
    act = '0;
    ph = PH_IDLE;
    el = 0;
    trun = 0;
    hl = 1;
    c_rto = RST_REPLY_TO;
    c_grace = RST_GRACE;
    c_lock = RST_LOCKOUT;
    c_lim = RST_TO_LIMIT;
    lock = c_lock;

    // Reset values with the boot lockout running.
    add_in(OP_SUBMIT, 16'hFFFF, CLS_EMPTY, 2'd3, 2'd3, 1'b1, 16'hFFFF);
    add_in(2'd3, 16'hFFFF, 2'd3, 2'd3, 2'd3, 1'b1, 16'hFFFF);
    add_in(OP_REPLY, 16'h0000, 2'd0, 2'd0, 2'd0, 1'b1, 16'hFFFF);
    add_in(OP_SUBMIT, 16'h0000, CLS_MOTION, RK_IMM, 2'd1, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'h1234, CLS_MOTION, RK_IMM, 2'd2, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'hA5A5, 2'd1, RK_NONE, 2'd0, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'h5A5A, 2'd1, 2'd2, 2'd3, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'h00FF, 2'd1, 2'd3, 2'd1, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'hFF00, CLS_URGENT, RK_IMM, 2'd2, 1'b0, 16'h0000);
    add_in(OP_SUBMIT, 16'h0F0F, CLS_MOTION, RK_IMM, 2'd3, 1'b0, 16'h0000);
    add_in(OP_TICK, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0);
    add_in(OP_REPLY, 16'h0, 2'd0, 2'd0, 2'd0, 1'b1, 16'h8001);
    add_in(OP_TICK, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0);
    add_in(OP_TICK, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0);
    add_in(OP_REPLY, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h7FFE);
    add_in(OP_TICK, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0);
    add_in(OP_REPLY, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0001);
    add_in(OP_TICK, 16'h0, 2'd0, 2'd0, 2'd0, 1'b0, 16'h0);
    for (int i = 0; i < 9; i++)
      add_in(OP_SUBMIT, 16'(i), 2'd1, RK_IMM, 2'(i), 1'b0, 16'h0);
    add_in(OP_SUBMIT, 16'hBEEF, CLS_MOTION, RK_IMM, 2'd1, 1'b0, 16'h0);

    add_setting(2, 1, 0, 1);
    add_random(70);
    stim_q.push_back('{ST_DRAIN, 2'd0, 40'd0, 2'd0, 16'd0});
    add_random(10);
    add_setting(65535, 1, 20, 15);
    add_random(50);
    add_setting(1, 65535, 65535, 0);
    add_random(45);
    add_setting(3, 2, 5, 3);
    add_random(60);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_q.size() == 0 && !in_tvalid && result_q.size() == 0);
    repeat (60) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, result_q.size());
      n_fail++;
    end
    $display("Ran %0d input transfers over five register settings, checked %0d results.",
             n_sent, n_checked);
    $display("Covered supersede, stop purge, full queue, lockout refusal and timeouts.");
    if (n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
